>>> sv/ouc_pkg.sv
// ----------------------------------------------------------------------------
// ouc_pkg
// Shared types and constants of the update command handler: command and
// reply codes, register indexes, reset values and the phase encoding.
// ----------------------------------------------------------------------------
package ouc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERSION_BYTE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUNNING_BANK = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BANK_A_BASE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BANK_B_BASE  = 3'd4;

    // register reset values
    localparam logic        RST_ENABLE       = 1'b1;
    localparam logic [7:0]  RST_VERSION_BYTE = 8'h01;
    localparam logic        RST_RUNNING_BANK = 1'b0;
    localparam logic [31:0] RST_BANK_A_BASE  = 32'h0802_0000;
    localparam logic [31:0] RST_BANK_B_BASE  = 32'h0806_0000;

    // command codes
    localparam logic [7:0] CMD_ECHO    = 8'h01;
    localparam logic [7:0] CMD_START   = 8'h10;
    localparam logic [7:0] CMD_CHUNK   = 8'h20;
    localparam logic [7:0] CMD_END     = 8'h30;
    localparam logic [7:0] CMD_VERSION = 8'h40;
    localparam logic [7:0] CMD_RESTART = 8'h50;
    localparam logic [7:0] CMD_BANK    = 8'h60;

    // reply codes
    localparam logic [7:0] RSP_NONE = 8'h00;
    localparam logic [7:0] RSP_ECHO = 8'h02;
    localparam logic [7:0] RSP_OK   = 8'hAA;
    localparam logic [7:0] RSP_ERR  = 8'hFF;

    localparam logic BANK_A = 1'b0;
    localparam logic BANK_B = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_LEN  = 3'b010,
        PH_DATA = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0]  reply;
        logic        flash_write;
        logic [31:0] write_address;
        logic [7:0]  write_data;
        logic        erase_request;
        logic        erase_bank;
        logic        record_request;
        logic        record_bank;
        logic        reboot_request;
        logic        activity_led;
    } result_t;

endpackage

>>> sv/ota_update_command_handler_unit.sv
// ----------------------------------------------------------------------------
// ota_update_command_handler_unit
// Byte-wide command handler for a two-bank firmware download over SPI.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one received SPI byte per request (command, chunk length or
//   data byte depending on the current phase).
//   m_ channel: exactly one result per request: reply byte (0 if none),
//   flash byte write, erase, boot record and reboot requests, LED level.
//   cfg_ port: plain register writes (enable, version, running bank, bank
//   base addresses), only while no request is in flight.
// Timing:
//   result valid in the cycle after accept; one request per cycle sustained
//   while m_ready is high, set by the single output register that holds the
//   result while the next byte is decoded against the updated state.
// Reset:
//   aresetn (synchronous, active low) returns to the idle command phase with
//   no update active, clears counters and LED and loads register defaults.
// Stall:
//   while m_ready is low a held result keeps s_ready low; nothing is dropped.
// ----------------------------------------------------------------------------
module ota_update_command_handler_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ouc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ouc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_rx_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_reply,
    output logic                             m_flash_write,
    output logic [31:0]                      m_write_address,
    output logic [7:0]                       m_write_data,
    output logic                             m_erase_request,
    output logic                             m_erase_bank,
    output logic                             m_record_request,
    output logic                             m_record_bank,
    output logic                             m_reboot_request,
    output logic                             m_activity_led
);
    import ouc_pkg::*;

    // configuration
    logic        enable_reg;
    logic [7:0]  version_byte_reg;
    logic        running_bank_reg;
    logic [31:0] bank_a_base_reg;
    logic [31:0] bank_b_base_reg;

    // handler state
    phase_t      phase_reg, phase_next;
    logic        update_active_reg, update_active_next;
    logic [31:0] next_address_reg, next_address_next;
    logic [9:0]  kb_count_reg, kb_count_next;
    logic [7:0]  chunk_length_reg, chunk_length_next;
    logic [7:0]  chunk_count_reg, chunk_count_next;
    logic        target_bank_reg, target_bank_next;
    logic        recorded_bank_reg, recorded_bank_next;
    logic        led_reg, led_next;

    result_t     result_reg, result_next;
    logic        m_valid_reg;
    logic        accept;

    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg       <= RST_ENABLE;
            version_byte_reg <= RST_VERSION_BYTE;
            running_bank_reg <= RST_RUNNING_BANK;
            bank_a_base_reg  <= RST_BANK_A_BASE;
            bank_b_base_reg  <= RST_BANK_B_BASE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ENABLE:       enable_reg       <= cfg_wdata[0];
                CFG_VERSION_BYTE: version_byte_reg <= cfg_wdata[7:0];
                CFG_RUNNING_BANK: running_bank_reg <= cfg_wdata[0];
                CFG_BANK_A_BASE:  bank_a_base_reg  <= cfg_wdata[31:0];
                CFG_BANK_B_BASE:  bank_b_base_reg  <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [9:0] kb_inc;
        logic [7:0] cnt_inc;
        phase_next         = phase_reg;
        update_active_next = update_active_reg;
        next_address_next  = next_address_reg;
        kb_count_next      = kb_count_reg;
        chunk_length_next  = chunk_length_reg;
        chunk_count_next   = chunk_count_reg;
        target_bank_next   = target_bank_reg;
        recorded_bank_next = recorded_bank_reg;
        led_next           = led_reg;
        result_next        = '0;
        kb_inc             = kb_count_reg + 10'd1;
        cnt_inc            = chunk_count_reg + 8'd1;

        if (enable_reg) begin
            unique case (phase_reg)
                PH_LEN: begin
                    chunk_length_next = s_rx_byte;
                    chunk_count_next  = 8'd0;
                    phase_next        = PH_DATA;
                end
                PH_DATA: begin
                    result_next.flash_write   = 1'b1;
                    result_next.write_address = next_address_reg;
                    result_next.write_data    = s_rx_byte;
                    next_address_next         = next_address_reg + 32'd1;
                    kb_count_next             = kb_inc;
                    chunk_count_next          = cnt_inc;
                    // led toggles on every 1024-byte wrap
                    if (kb_inc == 10'd0) begin
                        led_next = ~led_reg;
                    end
                    if (cnt_inc >= chunk_length_reg) begin
                        phase_next        = PH_IDLE;
                        result_next.reply = RSP_OK;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    unique case (s_rx_byte)
                        CMD_ECHO: begin
                            led_next          = ~led_reg;
                            result_next.reply = RSP_ECHO;
                        end
                        CMD_VERSION: begin
                            result_next.reply = version_byte_reg;
                        end
                        CMD_START: begin
                            led_next = 1'b1;
                            // target the bank we are not running from
                            if (running_bank_reg == BANK_A) begin
                                next_address_next      = bank_b_base_reg;
                                target_bank_next       = BANK_B;
                                result_next.erase_bank = BANK_B;
                            end else begin
                                next_address_next      = bank_a_base_reg;
                                target_bank_next       = BANK_A;
                                result_next.erase_bank = BANK_A;
                            end
                            result_next.erase_request = 1'b1;
                            update_active_next        = 1'b1;
                            kb_count_next             = 10'd0;
                            result_next.reply         = RSP_OK;
                        end
                        CMD_CHUNK: begin
                            if (update_active_reg) begin
                                phase_next = PH_LEN;
                            end else begin
                                result_next.reply = RSP_ERR;
                            end
                        end
                        CMD_END: begin
                            if (update_active_reg) begin
                                update_active_next         = 1'b0;
                                recorded_bank_next         = target_bank_reg;
                                result_next.record_request = 1'b1;
                                result_next.record_bank    = target_bank_reg;
                                led_next                   = 1'b0;
                                result_next.reply          = RSP_OK;
                            end else begin
                                result_next.reply = RSP_ERR;
                            end
                        end
                        CMD_RESTART: begin
                            result_next.reboot_request = 1'b1;
                            result_next.reply          = RSP_OK;
                        end
                        CMD_BANK: begin
                            result_next.reply = {7'd0, recorded_bank_reg};
                        end
                        default: ;
                    endcase
                end
            endcase
        end
        result_next.activity_led = led_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            update_active_reg <= 1'b0;
            next_address_reg  <= 32'd0;
            kb_count_reg      <= 10'd0;
            chunk_length_reg  <= 8'd0;
            chunk_count_reg   <= 8'd0;
            target_bank_reg   <= BANK_A;
            recorded_bank_reg <= BANK_A;
            led_reg           <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg         <= phase_next;
                update_active_reg <= update_active_next;
                next_address_reg  <= next_address_next;
                kb_count_reg      <= kb_count_next;
                chunk_length_reg  <= chunk_length_next;
                chunk_count_reg   <= chunk_count_next;
                target_bank_reg   <= target_bank_next;
                recorded_bank_reg <= recorded_bank_next;
                led_reg           <= led_next;
                m_valid_reg       <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_reply          = result_reg.reply;
    assign m_flash_write    = result_reg.flash_write;
    assign m_write_address  = result_reg.write_address;
    assign m_write_data     = result_reg.write_data;
    assign m_erase_request  = result_reg.erase_request;
    assign m_erase_bank     = result_reg.erase_bank;
    assign m_record_request = result_reg.record_request;
    assign m_record_bank    = result_reg.record_bank;
    assign m_reboot_request = result_reg.reboot_request;
    assign m_activity_led   = result_reg.activity_led;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the update command handler. A directed table walks
// every command, the error replies and the chunk corner cases; random update
// sessions with noise follow under several register settings. Every result
// is compared field by field with an in-bench model of the handler.
// ----------------------------------------------------------------------------
module testbench;
    import ouc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 100000;

    typedef struct packed {
        logic [7:0] rx;
        logic       known;
        logic [7:0] reply;
    } directed_row_t;

    typedef struct packed {
        logic       known;
        logic [7:0] reply;
    } typed_reply_t;

    // reply typed in where it is obvious, otherwise taken from the model
    localparam directed_row_t DIRECTED [25] = '{
        '{CMD_BANK,    1'b1, RSP_NONE},
        '{CMD_VERSION, 1'b1, RST_VERSION_BYTE},
        '{CMD_ECHO,    1'b1, RSP_ECHO},
        '{CMD_CHUNK,   1'b1, RSP_ERR},
        '{CMD_END,     1'b1, RSP_ERR},
        '{8'h00,       1'b1, RSP_NONE},
        '{8'hFF,       1'b1, RSP_NONE},
        '{CMD_RESTART, 1'b1, RSP_OK},
        '{CMD_START,   1'b1, RSP_OK},
        '{CMD_CHUNK,   1'b0, RSP_NONE},
        '{8'h00,       1'b0, RSP_NONE},
        '{8'hFF,       1'b0, RSP_NONE},
        '{CMD_CHUNK,   1'b0, RSP_NONE},
        '{8'h02,       1'b0, RSP_NONE},
        '{8'h00,       1'b0, RSP_NONE},
        '{8'hFF,       1'b0, RSP_NONE},
        '{CMD_ECHO,    1'b1, RSP_ECHO},
        '{CMD_END,     1'b1, RSP_OK},
        '{CMD_BANK,    1'b1, {7'd0, BANK_B}},
        '{CMD_START,   1'b1, RSP_OK},
        '{CMD_START,   1'b1, RSP_OK},
        '{CMD_CHUNK,   1'b0, RSP_NONE},
        '{8'h01,       1'b0, RSP_NONE},
        '{8'h80,       1'b0, RSP_NONE},
        '{CMD_END,     1'b1, RSP_OK}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_rx_byte = 8'h00;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [7:0]             m_reply;
    logic                   m_flash_write;
    logic [31:0]            m_write_address;
    logic [7:0]             m_write_data;
    logic                   m_erase_request;
    logic                   m_erase_bank;
    logic                   m_record_request;
    logic                   m_record_bank;
    logic                   m_reboot_request;
    logic                   m_activity_led;

    ota_update_command_handler_unit uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_reply          (m_reply),
        .m_flash_write    (m_flash_write),
        .m_write_address  (m_write_address),
        .m_write_data     (m_write_data),
        .m_erase_request  (m_erase_request),
        .m_erase_bank     (m_erase_bank),
        .m_record_request (m_record_request),
        .m_record_bank    (m_record_bank),
        .m_reboot_request (m_reboot_request),
        .m_activity_led   (m_activity_led)
    );

    // register copies
    logic        reg_enable;
    logic [7:0]  reg_version;
    logic        reg_running_bank;
    logic [31:0] reg_base_a;
    logic [31:0] reg_base_b;

    // handler state
    phase_t      cur_phase;
    logic        upd_active;
    logic [31:0] flash_addr;
    logic [9:0]  kb_count;
    logic [7:0]  chunk_len;
    logic [7:0]  chunk_cnt;
    logic        tgt_bank;
    logic        rec_bank;
    logic        led;

    result_t      expected_results [$];
    typed_reply_t typed_replies [$];

    int unsigned n_sent       = 0;
    int unsigned n_results    = 0;
    int unsigned n_errors     = 0;
    int unsigned n_writes     = 0;
    int unsigned n_erases     = 0;
    int unsigned n_records    = 0;
    int unsigned cycle_count  = 0;
    bit          steady       = 1'b0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached, %0d of %0d results seen", $time, n_results, n_sent);
        $display("testbench: FAIL");
        $finish;
    end

    function automatic void reset_handler_model();
        reg_enable       = RST_ENABLE;
        reg_version      = RST_VERSION_BYTE;
        reg_running_bank = RST_RUNNING_BANK;
        reg_base_a       = RST_BANK_A_BASE;
        reg_base_b       = RST_BANK_B_BASE;
        cur_phase        = PH_IDLE;
        upd_active       = 1'b0;
        flash_addr       = '0;
        kb_count         = '0;
        chunk_len        = '0;
        chunk_cnt        = '0;
        tgt_bank         = BANK_A;
        rec_bank         = BANK_A;
        led              = 1'b0;
    endfunction

    function automatic result_t handle_byte(input logic [7:0] rx);
        result_t r;
        r = '0;
        if (reg_enable) begin
            if (cur_phase == PH_LEN) begin
                chunk_len = rx;
                chunk_cnt = '0;
                cur_phase = PH_DATA;
            end else if (cur_phase == PH_DATA) begin
                r.flash_write   = 1'b1;
                r.write_address = flash_addr;
                r.write_data    = rx;
                flash_addr      = flash_addr + 32'd1;
                kb_count        = kb_count + 10'd1;
                chunk_cnt       = chunk_cnt + 8'd1;
                if (kb_count == 10'd0) begin
                    led = ~led;
                end
                // a zero length chunk acks on its first byte
                if (chunk_cnt >= chunk_len) begin
                    cur_phase = PH_IDLE;
                    r.reply   = RSP_OK;
                end
            end else begin
                cur_phase = PH_IDLE;
                case (rx)
                    CMD_ECHO: begin
                        led     = ~led;
                        r.reply = RSP_ECHO;
                    end
                    CMD_VERSION: begin
                        r.reply = reg_version;
                    end
                    CMD_START: begin
                        led = 1'b1;
                        // program the bank that is not running
                        if (reg_running_bank == BANK_A) begin
                            flash_addr = reg_base_b;
                            tgt_bank   = BANK_B;
                        end else begin
                            flash_addr = reg_base_a;
                            tgt_bank   = BANK_A;
                        end
                        r.erase_request = 1'b1;
                        r.erase_bank    = tgt_bank;
                        upd_active      = 1'b1;
                        kb_count        = '0;
                        r.reply         = RSP_OK;
                    end
                    CMD_CHUNK: begin
                        if (upd_active) begin
                            cur_phase = PH_LEN;
                        end else begin
                            r.reply = RSP_ERR;
                        end
                    end
                    CMD_END: begin
                        if (upd_active) begin
                            upd_active       = 1'b0;
                            rec_bank         = tgt_bank;
                            r.record_request = 1'b1;
                            r.record_bank    = tgt_bank;
                            led              = 1'b0;
                            r.reply          = RSP_OK;
                        end else begin
                            r.reply = RSP_ERR;
                        end
                    end
                    CMD_RESTART: begin
                        r.reboot_request = 1'b1;
                        r.reply          = RSP_OK;
                    end
                    CMD_BANK: begin
                        r.reply = {7'd0, rec_bank};
                    end
                    default: begin
                    end
                endcase
            end
        end
        r.activity_led = led;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
        end
    endfunction

    always @(posedge aclk) begin
        m_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
    end

    always @(posedge aclk) begin : monitor
        result_t      exp_r;
        result_t      got_r;
        typed_reply_t tr;
        if (aresetn && s_valid && s_ready) begin
            exp_r = handle_byte(s_rx_byte);
            if (typed_replies.size() != 0) begin
                tr = typed_replies.pop_front();
                if (tr.known) begin
                    exp_r.reply = tr.reply;
                end
            end
            expected_results.push_back(exp_r);
        end
        if (aresetn && m_valid && m_ready) begin
            got_r = '{m_reply, m_flash_write, m_write_address, m_write_data,
                      m_erase_request, m_erase_bank, m_record_request,
                      m_record_bank, m_reboot_request, m_activity_led};
            n_results++;
            n_writes  += 32'(got_r.flash_write);
            n_erases  += 32'(got_r.erase_request);
            n_records += 32'(got_r.record_request);
            if (expected_results.size() == 0) begin
                n_errors++;
                $display("%0t: result with nothing expected, reply %h", $time, got_r.reply);
            end else begin
                exp_r = expected_results.pop_front();
                check_field("reply", 32'(exp_r.reply), 32'(got_r.reply));
                check_field("flash_write", 32'(exp_r.flash_write), 32'(got_r.flash_write));
                check_field("write_address", exp_r.write_address, got_r.write_address);
                check_field("write_data", 32'(exp_r.write_data), 32'(got_r.write_data));
                check_field("erase_request", 32'(exp_r.erase_request),
                            32'(got_r.erase_request));
                check_field("erase_bank", 32'(exp_r.erase_bank), 32'(got_r.erase_bank));
                check_field("record_request", 32'(exp_r.record_request),
                            32'(got_r.record_request));
                check_field("record_bank", 32'(exp_r.record_bank), 32'(got_r.record_bank));
                check_field("reboot_request", 32'(exp_r.reboot_request),
                            32'(got_r.reboot_request));
                check_field("activity_led", 32'(exp_r.activity_led),
                            32'(got_r.activity_led));
            end
        end
    end

    // drives the byte and returns once s_ready reads high
    task automatic push_byte(input logic [7:0] value, input logic known = 1'b0,
                             input logic [7:0] reply = RSP_NONE);
        int unsigned gap;
        gap = 0;
        typed_replies.push_back('{known, reply});
        if (!steady) begin
            while ($urandom_range(0, 99) < 33) gap++;
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (n_results < n_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_index <= idx;
        cfg_wdata <= data;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_ENABLE:       reg_enable       = data[0];
            CFG_VERSION_BYTE: reg_version      = data[7:0];
            CFG_RUNNING_BANK: reg_running_bank = data[0];
            CFG_BANK_A_BASE:  reg_base_a       = data;
            CFG_BANK_B_BASE:  reg_base_b       = data;
            default: begin
            end
        endcase
    endtask

    task automatic set_config(input logic en, input logic [7:0] ver, input logic run_bank,
                              input logic [31:0] base_a, input logic [31:0] base_b);
        write_reg(CFG_ENABLE, {31'd0, en});
        write_reg(CFG_VERSION_BYTE, {24'd0, ver});
        write_reg(CFG_RUNNING_BANK, {31'd0, run_bank});
        write_reg(CFG_BANK_A_BASE, base_a);
        write_reg(CFG_BANK_B_BASE, base_b);
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0:       return CMD_ECHO;
            1:       return CMD_VERSION;
            2:       return CMD_RESTART;
            3:       return CMD_BANK;
            4:       return CMD_CHUNK;
            5:       return CMD_END;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 8'($urandom_range(0, 8));
        if (r < 92) return 8'($urandom_range(9, 64));
        return 8'($urandom_range(65, 255));
    endfunction

    task automatic send_chunk(input logic [7:0] len);
        push_byte(CMD_CHUNK);
        push_byte(len);
        repeat ((len == 8'd0) ? 1 : int'(len)) push_byte(8'($urandom_range(0, 255)));
    endtask

    // mostly well-formed sessions, with stray commands and broken chunks mixed in
    task automatic run_sessions(input int unsigned count);
        int unsigned stop_at;
        int unsigned r;
        bit          open;
        stop_at = n_sent + count;
        open    = 1'b0;
        while (n_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (!open && r < 55) begin
                push_byte(CMD_START);
                open = 1'b1;
            end else if (open && r < 6) begin
                push_byte(CMD_START);
            end else if (open && r < 72) begin
                send_chunk(pick_length());
            end else if (open && r < 80) begin
                push_byte(CMD_END);
                open = 1'b0;
            end else begin
                push_byte(noise_byte());
            end
        end
    endtask

    task automatic run_noise(input int unsigned count);
        repeat (count) begin
            push_byte(($urandom_range(0, 5) == 0) ? CMD_START : noise_byte());
        end
    endtask

    initial begin
        reset_handler_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            push_byte(DIRECTED[i].rx, DIRECTED[i].known, DIRECTED[i].reply);
        end
        wait_idle();

        // bank A target near the top of the address space, so writes wrap
        set_config(1'b1, 8'h00, BANK_B, 32'hFFFF_FFF8, 32'h0000_0000);
        run_sessions(150);
        wait_idle();

        write_reg(CFG_ENABLE, 32'd0);
        run_noise(40);
        wait_idle();

        // one session long enough for the kilobyte LED toggle
        set_config(1'b1, 8'hFF, BANK_A, 32'h0000_0000, 32'hFFFF_FFFF);
        push_byte(CMD_START);
        repeat (4) send_chunk(8'd255);
        send_chunk(8'd16);
        push_byte(CMD_ECHO);
        push_byte(CMD_END);
        run_sessions(40);
        wait_idle();

        set_config(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   $urandom, $urandom);
        steady = 1'b1;
        run_sessions(250);
        steady = 1'b0;
        wait_idle();

        write_reg(CFG_ENABLE, 32'd0);
        run_noise(30);
        wait_idle();

        set_config(RST_ENABLE, RST_VERSION_BYTE, RST_RUNNING_BANK,
                   RST_BANK_A_BASE, RST_BANK_B_BASE);
        run_sessions(150);
        wait_idle();
        repeat (8) @(posedge aclk);

        if (expected_results.size() != 0) begin
            n_errors++;
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
        end
        $display("summary: %0d requests, %0d results compared, %0d mismatches",
                 n_sent, n_results, n_errors);
        $display("summary: %0d flash byte writes, %0d erases, %0d boot record updates",
                 n_writes, n_erases, n_records);
        if (n_errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/ouc_pkg.sv
sv/ota_update_command_handler_unit.sv
dv/testbench.sv
